// ===== sv/imu_complementary_tilt_filter_core_macros.svh =====
// Assertion macros for the IMU complementary tilt filter core.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_CORE_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IMUCTF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imuctf assertion failed");

// Next-cycle implication, disabled during reset.
`define IMUCTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imuctf assertion failed");

`endif

// ===== sv/imuctf_pkg.sv =====
// Package for the IMU complementary tilt filter core: item types, constants,
// arctangent table and saturation helper. No dependencies.
`default_nettype none

package imuctf_pkg;

  localparam int unsigned CordicSteps = 18;
  localparam int unsigned RootSteps   = 24;
  localparam int unsigned DivSteps    = 44;
  localparam int unsigned MacSteps    = 16;

  localparam logic [15:0] AlphaReset = 16'd64225;
  localparam logic signed [23:0] SmallAngle = 24'sd66;
  localparam logic signed [24:0] Angle90 = 25'sd5898240;
  localparam logic signed [15:0] SmallAccel = 16'sd4;
  localparam logic [10:0] DivConst = 11'd1000;
  localparam logic [43:0] DivHalf = 44'd500;

  // One input item.
  typedef struct packed {
    logic              sensor_sel;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [15:0] elapsed_ms;
  } imu_in_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] filt_x;
    logic signed [31:0] filt_y;
    logic signed [31:0] filt_z;
    logic signed [31:0] integ_x;
    logic signed [31:0] integ_y;
    logic signed [31:0] integ_z;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
  } imu_out_t;

  // atan(2^-i) in Q16.16 degrees, rounded.
  function automatic logic [22:0] atan_lut(input logic [4:0] idx);
    logic [22:0] v;
    unique case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  // Clamp a 40-bit signed value to the int32 range.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/imu_complementary_tilt_filter_core.sv =====
// Two-IMU complementary tilt filter. Each item is one IMU sample; it yields one result
// item with the sensor's filtered and gyro-integrated angles (Q16.16 degrees) and the
// sensor 1 minus sensor 0 x/y differences. One item is worked at a time, axis by axis:
// a bit-serial square root, an 18-step CORDIC arctangent, a bit-serial divide by 1000
// for the gyro increment and a serial alpha multiply. The result sits in an output
// register, so the next item can be accepted while it waits. blend_alpha is at APB
// byte address 0.
// Depends on imuctf_pkg and imu_complementary_tilt_filter_core_macros.svh.
`default_nettype none
`include "imu_complementary_tilt_filter_core_macros.svh"

module imu_complementary_tilt_filter_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire imuctf_pkg::imu_in_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output imuctf_pkg::imu_out_t      out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SQ   = 13'b0000000000010,
    S_RLD  = 13'b0000000000100,
    S_ROOT = 13'b0000000001000,
    S_CLD  = 13'b0000000010000,
    S_ROT  = 13'b0000000100000,
    S_GLD  = 13'b0000001000000,
    S_DLD  = 13'b0000010000000,
    S_DIV  = 13'b0000100000000,
    S_MLD  = 13'b0001000000000,
    S_MAC  = 13'b0010000000000,
    S_WB   = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] axis_q, axis_d;

  imuctf_pkg::imu_in_t  in_q;
  imuctf_pkg::imu_out_t out_q;
  logic out_valid_q;
  logic [15:0] alpha_q;

  logic signed [31:0] filt_q  [2][3];
  logic signed [31:0] integ_q [2][3];

  // datapath registers
  logic [31:0] sq_q;
  logic [47:0] rn_q;
  logic [23:0] root_q;
  logic [25:0] rrem_q;
  logic signed [26:0] cx_q, cy_q;
  logic signed [24:0] cz_q;
  logic neg_q, zero_q, small_q;
  logic signed [23:0] ang_q;
  logic signed [32:0] prod_q;
  logic [43:0] dq_q;
  logic [9:0]  drem_q;
  logic signed [53:0] mac_q, mc_q;
  logic [15:0] al_q;

  logic acc_in, cfg_wr, fin_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign acc_in      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign prdata      = paddr[2] ? 32'd0 : {16'd0, alpha_q};
  assign fin_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // Per-axis operand selection
  logic signed [15:0] sq_a, sq_b, guard, rate_sel;
  logic signed [16:0] plain;
  logic z_axis;
  always_comb begin
    unique case (axis_q)
      2'd0: begin
        sq_a = in_q.accel_x; sq_b = in_q.accel_z; guard = in_q.accel_x;
        plain = {in_q.accel_y[15], in_q.accel_y}; rate_sel = in_q.rate_x; z_axis = 1'b0;
      end
      2'd1: begin
        sq_a = in_q.accel_y; sq_b = in_q.accel_z; guard = in_q.accel_y;
        plain = 17'sd0 - {in_q.accel_x[15], in_q.accel_x};
        rate_sel = in_q.rate_y; z_axis = 1'b0;
      end
      default: begin
        sq_a = in_q.accel_x; sq_b = in_q.accel_y; guard = in_q.accel_z;
        plain = {in_q.accel_z[15], in_q.accel_z}; rate_sel = in_q.rate_z; z_axis = 1'b1;
      end
    endcase
  end

  // Squares and rate product
  logic signed [31:0] sqa_w, sqb_w;
  logic signed [32:0] prod_w;
  logic [31:0] sqsum;
  assign sqa_w  = sq_a * sq_a;
  assign sqb_w  = sq_b * sq_b;
  assign sqsum  = sq_q + sqb_w;
  assign prod_w = rate_sel * $signed({1'b0, in_q.elapsed_ms});

  // Square root digit step
  logic [27:0] rnext, rtrial;
  logic rge;
  assign rnext  = {rrem_q, rn_q[47:46]};
  assign rtrial = {2'b00, root_q, 2'b01};
  assign rge    = rnext >= rtrial;

  // CORDIC init values
  logic [16:0] plain_mag;
  logic [26:0] scaled_mag, root_ext;
  assign plain_mag  = plain[16] ? 17'(-plain) : plain;
  assign scaled_mag = {2'b00, plain_mag, 8'd0};
  assign root_ext   = {3'd0, root_q};

  // CORDIC step
  logic [4:0] ci;
  logic signed [26:0] cdx, cdy, cneg_y;
  logic signed [24:0] ctab;
  assign ci     = cnt_q[4:0];
  assign cneg_y = -cy_q;
  assign cdx    = cy_q[26] ? -(cneg_y >>> ci) : (cy_q >>> ci);
  assign cdy    = cx_q >>> ci;
  assign ctab   = $signed({2'b00, imuctf_pkg::atan_lut(ci)});

  // CORDIC finish: clamp, sign, special cases
  logic signed [24:0] zc;
  logic signed [23:0] ang_w;
  always_comb begin
    if (cz_q < 25'sd0) begin
      zc = 25'sd0;
    end else if (cz_q > imuctf_pkg::Angle90) begin
      zc = imuctf_pkg::Angle90;
    end else begin
      zc = cz_q;
    end
    priority if (small_q) begin
      ang_w = imuctf_pkg::SmallAngle;
    end else if (zero_q) begin
      ang_w = 24'sd0;
    end else begin
      ang_w = neg_q ? 24'(-zc) : zc[23:0];
    end
  end

  // Divide-by-1000 step
  logic [31:0] pabs;
  logic [10:0] dt;
  logic dge;
  assign pabs = prod_q[32] ? 32'(-prod_q) : prod_q[31:0];
  assign dt   = {drem_q, dq_q[43]};
  assign dge  = dt >= imuctf_pkg::DivConst;

  // Increment, prediction, integral
  logic signed [34:0] inc;
  logic signed [35:0] pred, isum;
  logic signed [36:0] diff;
  logic signed [31:0] filt_cur, integ_cur;
  logic gneg_q;
  assign filt_cur  = filt_q[in_q.sensor_sel][axis_q];
  assign integ_cur = integ_q[in_q.sensor_sel][axis_q];
  assign inc  = gneg_q ? -$signed({1'b0, dq_q[33:0]}) : $signed({1'b0, dq_q[33:0]});
  assign pred = 36'(filt_cur) + 36'(inc);
  assign isum = 36'(integ_cur) + 36'(inc);
  assign diff = 37'(pred) - 37'(ang_q);

  // Rounding of the blend sum by 2^16, half away from zero
  logic signed [53:0] mac_r;
  logic signed [37:0] rnd;
  assign mac_r = mac_q + (mac_q[53] ? 54'sd32767 : 54'sd32768);
  assign rnd   = mac_r[53:16];

  // Sensor differences
  logic signed [32:0] dlt_x, dlt_y;
  assign dlt_x = 33'(filt_q[1][0]) - 33'(filt_q[0][0]);
  assign dlt_y = 33'(filt_q[1][1]) - 33'(filt_q[0][1]);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    unique case (state_q)
      S_IDLE: if (acc_in) begin
        state_d = S_SQ; axis_d = 2'd0;
      end
      S_SQ:  state_d = S_RLD;
      S_RLD: begin state_d = S_ROOT; cnt_d = '0; end
      S_ROOT: begin
        if (cnt_q == 6'(imuctf_pkg::RootSteps - 1)) begin
          state_d = S_CLD; cnt_d = '0;
        end else cnt_d = cnt_q + 6'd1;
      end
      S_CLD: begin state_d = S_ROT; cnt_d = '0; end
      S_ROT: begin
        if (cnt_q == 6'(imuctf_pkg::CordicSteps - 1)) begin
          state_d = S_GLD; cnt_d = '0;
        end else cnt_d = cnt_q + 6'd1;
      end
      S_GLD: state_d = S_DLD;
      S_DLD: begin state_d = S_DIV; cnt_d = '0; end
      S_DIV: begin
        if (cnt_q == 6'(imuctf_pkg::DivSteps - 1)) begin
          state_d = S_MLD; cnt_d = '0;
        end else cnt_d = cnt_q + 6'd1;
      end
      S_MLD: begin state_d = S_MAC; cnt_d = '0; end
      S_MAC: begin
        if (cnt_q == 6'(imuctf_pkg::MacSteps - 1)) begin
          state_d = S_WB; cnt_d = '0;
        end else cnt_d = cnt_q + 6'd1;
      end
      S_WB: begin
        if (axis_q == 2'd2) state_d = S_FIN;
        else begin
          state_d = S_SQ; axis_d = axis_q + 2'd1;
        end
      end
      S_FIN: if (fin_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      alpha_q     <= imuctf_pkg::AlphaReset;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      if (fin_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_wr && !paddr[2]) alpha_q <= pwdata[15:0];
    end
  end

  // Per-sensor angle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        for (int a = 0; a < 3; a++) begin
          filt_q[s][a]  <= '0;
          integ_q[s][a] <= '0;
        end
      end
    end else begin
      if (state_q == S_MLD) integ_q[in_q.sensor_sel][axis_q] <=
          imuctf_pkg::sat32(40'(isum));
      if (state_q == S_WB) filt_q[in_q.sensor_sel][axis_q] <=
          imuctf_pkg::sat32(40'(rnd));
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (acc_in) in_q <= in_data_i;
    unique case (state_q)
      S_SQ: sq_q <= sqa_w;
      S_RLD: begin
        rn_q <= {sqsum, 16'd0}; root_q <= '0; rrem_q <= '0;
      end
      S_ROOT: begin
        rn_q <= {rn_q[45:0], 2'b00};
        if (rge) begin
          rrem_q <= 26'(rnext - rtrial); root_q <= {root_q[22:0], 1'b1};
        end else begin
          rrem_q <= rnext[25:0]; root_q <= {root_q[22:0], 1'b0};
        end
      end
      S_CLD: begin
        cz_q    <= '0;
        small_q <= (guard >= -imuctf_pkg::SmallAccel) && (guard <= imuctf_pkg::SmallAccel);
        if (z_axis) begin
          cx_q <= scaled_mag; cy_q <= root_ext;
          neg_q <= plain[16]; zero_q <= (root_q == '0);
        end else begin
          cx_q <= root_ext; cy_q <= scaled_mag;
          neg_q <= plain[16]; zero_q <= (plain == '0);
        end
      end
      S_ROT: begin
        if (cy_q > 27'sd0) begin
          cx_q <= cx_q + cdx; cy_q <= cy_q - cdy; cz_q <= cz_q + ctab;
        end else begin
          cx_q <= cx_q - cdx; cy_q <= cy_q + cdy; cz_q <= cz_q - ctab;
        end
      end
      S_GLD: begin
        ang_q <= ang_w; prod_q <= prod_w;
      end
      S_DLD: begin
        dq_q <= {pabs, 12'd0} + imuctf_pkg::DivHalf;
        drem_q <= '0; gneg_q <= prod_q[32];
      end
      S_DIV: begin
        dq_q   <= {dq_q[42:0], dge};
        drem_q <= dge ? 10'(dt - imuctf_pkg::DivConst) : dt[9:0];
      end
      S_MLD: begin
        mac_q <= {{14{ang_q[23]}}, ang_q, 16'd0};
        mc_q  <= 54'(diff);
        al_q  <= alpha_q;
      end
      S_MAC: begin
        if (al_q[0]) mac_q <= mac_q + mc_q;
        mc_q <= {mc_q[52:0], 1'b0};
        al_q <= {1'b0, al_q[15:1]};
      end
      default: ;
    endcase
    if (fin_load) begin
      out_q.filt_x  <= filt_q[in_q.sensor_sel][0];
      out_q.filt_y  <= filt_q[in_q.sensor_sel][1];
      out_q.filt_z  <= filt_q[in_q.sensor_sel][2];
      out_q.integ_x <= integ_q[in_q.sensor_sel][0];
      out_q.integ_y <= integ_q[in_q.sensor_sel][1];
      out_q.integ_z <= integ_q[in_q.sensor_sel][2];
      out_q.delta_x <= imuctf_pkg::sat32(40'(dlt_x));
      out_q.delta_y <= imuctf_pkg::sat32(40'(dlt_y));
    end
  end

  // Checks
  `IMUCTF_ASSERT_NEXT(a_busy_after_accept, acc_in, !in_ready_o)
  `IMUCTF_ASSERT_IMPL(a_out_from_fin, $rose(out_valid_q), $past(state_q == S_FIN))
  `IMUCTF_ASSERT_IMPL(a_alpha_by_write, !$stable(alpha_q), $past(cfg_wr))
  `IMUCTF_ASSERT_IMPL(a_rot_count, state_q == S_ROT, cnt_q < 6'(imuctf_pkg::CordicSteps))

endmodule

`default_nettype wire

// ===== dv/tb_imu_complementary_tilt_filter_core.sv =====
// Self-checking testbench for imu_complementary_tilt_filter_core: a directed table and then
// random IMU samples over several blend_alpha settings, checked against typed-in results or a built-in predictor.
// Depends on imuctf_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_imu_complementary_tilt_filter_core;

  localparam logic [2:0] AddrBlendAlpha = 3'd0;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned RxHoldCycles = 3000;
  localparam int unsigned ItemsPerPhase = 90;
  localparam int unsigned NumPhases = 6;

  // One directed row: sample plus an optional typed-in result.
  typedef struct packed {
    imuctf_pkg::imu_in_t  smp;
    logic                 has_exp;
    imuctf_pkg::imu_out_t res;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  imuctf_pkg::imu_in_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  imuctf_pkg::imu_out_t out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // Predictor state: per sensor*3+axis.
  longint               filt_st[6];
  longint               integ_st[6];
  longint               alpha_cfg;
  imuctf_pkg::imu_out_t tilt_expect_q[$];
  int unsigned          err_cnt;
  int unsigned          rx_cnt;
  int unsigned          idle_cnt;

  imu_complementary_tilt_filter_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic longint mag_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_div(longint v, longint d);
    longint m;
    m = (mag_l(v) + d / 2) / d;
    return (v < 0) ? -m : m;
  endfunction

  // floor(sqrt((a^2+b^2) << 16))
  function automatic longint hyp_root(longint a, longint b);
    longint unsigned n, res, bit_v;
    n = longint'(a * a + b * b) << 16;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return longint'(res);
  endfunction

  // CORDIC vectoring arctangent in Q16.16 degrees; signs handled outside the loop
  function automatic longint tilt_atan(longint num, longint den);
    longint atab[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                         14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
    longint x, y, z, dx, dy;
    logic   neg;
    x = mag_l(den);
    y = mag_l(num);
    z = 0;
    neg = (num < 0) != (den < 0);
    if (num == 0) return 0;
    for (int i = 0; i < 18; i++) begin
      dx = (y < 0) ? -((-y) >>> i) : (y >>> i);
      dy = (x < 0) ? -((-x) >>> i) : (x >>> i);
      if (y > 0) begin
        x += dx; y -= dy; z += atab[i];
      end else begin
        x -= dx; y += dy; z -= atab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 5898240) z = 5898240;
    return neg ? -z : z;
  endfunction

  // Advance the filter state for one sample and return its result item.
  function automatic imuctf_pkg::imu_out_t tilt_predict(imuctf_pkg::imu_in_t s);
    longint               ax, ay, az, dt, inc, pred, sum;
    longint               rate[3], acc[3];
    int                   b;
    imuctf_pkg::imu_out_t o;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    dt = s.elapsed_ms;
    rate[0] = s.rate_x;
    rate[1] = s.rate_y;
    rate[2] = s.rate_z;
    b = s.sensor_sel ? 3 : 0;
    // small guard axis gives the fixed tiny angle
    acc[0] = (mag_l(ax) > 4) ? tilt_atan(ay * 256, hyp_root(ax, az)) : 66;
    acc[1] = (mag_l(ay) > 4) ? tilt_atan(-ax * 256, hyp_root(ay, az)) : 66;
    acc[2] = (mag_l(az) > 4) ? tilt_atan(hyp_root(ax, ay), az * 256) : 66;
    for (int k = 0; k < 3; k++) begin
      inc = round_div(rate[k] * dt * 4096, 1000);
      pred = filt_st[b+k] + inc;
      sum = alpha_cfg * pred + (65536 - alpha_cfg) * acc[k];
      integ_st[b+k] = clamp32(integ_st[b+k] + inc);
      filt_st[b+k] = clamp32(round_div(sum, 65536));
    end
    o.filt_x  = 32'(filt_st[b]);
    o.filt_y  = 32'(filt_st[b+1]);
    o.filt_z  = 32'(filt_st[b+2]);
    o.integ_x = 32'(integ_st[b]);
    o.integ_y = 32'(integ_st[b+1]);
    o.integ_z = 32'(integ_st[b+2]);
    o.delta_x = 32'(clamp32(filt_st[3] - filt_st[0]));
    o.delta_y = 32'(clamp32(filt_st[4] - filt_st[1]));
    return o;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [15:0] rand_accel();
    int unsigned m;
    m = $urandom_range(0, 99);
    if (m < 30) return 16'($urandom);
    if (m < 80) return 16'($urandom_range(0, 10000) - 5000);
    if (m < 92) return 16'($urandom_range(0, 8) - 4);
    return 16'($urandom_range(0, 12) - 6);
  endfunction

  function automatic logic [15:0] rand_rate();
    if ($urandom_range(0, 99) < 30) return 16'($urandom);
    return 16'($urandom_range(0, 4000) - 2000);
  endfunction

  function automatic imuctf_pkg::imu_in_t rand_sample();
    imuctf_pkg::imu_in_t s;
    int unsigned         m;
    s.sensor_sel = 1'($urandom);
    s.accel_x = rand_accel();
    s.accel_y = rand_accel();
    s.accel_z = rand_accel();
    s.rate_x = rand_rate();
    s.rate_y = rand_rate();
    s.rate_z = rand_rate();
    m = $urandom_range(0, 99);
    if (m < 70) s.elapsed_ms = 16'($urandom_range(0, 300));
    else if (m < 90) s.elapsed_ms = 16'($urandom);
    else s.elapsed_ms = 16'd0;
    return s;
  endfunction

  function automatic int unsigned pick_gap(logic burst);
    int unsigned m;
    if (burst) return 0;
    m = $urandom_range(0, 99);
    if (m < 55) return 0;
    if (m < 88) return $urandom_range(1, 3);
    if (m < 97) return $urandom_range(5, 30);
    return $urandom_range(40, 120);
  endfunction

  // Offer one sample; predict at the edge it is taken.
  task automatic send_sample(imuctf_pkg::imu_in_t s, logic has_exp,
                             imuctf_pkg::imu_out_t res, logic burst);
    int unsigned          gap;
    imuctf_pkg::imu_out_t pr;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    pr = tilt_predict(s);
    tilt_expect_q.push_back(has_exp ? res : pr);
  endtask

  task automatic write_alpha(logic [15:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrBlendAlpha;
    pwdata  <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    alpha_cfg = val;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tilt_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      err_cnt++;
    end
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    imuctf_pkg::imu_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rx_cnt++;
      if (tilt_expect_q.size() == 0) begin
        $error("result item with nothing expected");
        err_cnt++;
      end else begin
        e = tilt_expect_q.pop_front();
        cmp_field("filt_x", e.filt_x, out_data_o.filt_x);
        cmp_field("filt_y", e.filt_y, out_data_o.filt_y);
        cmp_field("filt_z", e.filt_z, out_data_o.filt_z);
        cmp_field("integ_x", e.integ_x, out_data_o.integ_x);
        cmp_field("integ_y", e.integ_y, out_data_o.integ_y);
        cmp_field("integ_z", e.integ_z, out_data_o.integ_z);
        cmp_field("delta_x", e.delta_x, out_data_o.delta_x);
        cmp_field("delta_y", e.delta_y, out_data_o.delta_y);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back up the pipeline
  initial begin
    logic        held;
    int unsigned m;
    held = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && rx_cnt >= 20) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
      end
      m = $urandom_range(0, 99);
      if (m < 50) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else if (m < 85) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else if (m < 95) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(20, 400)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (1500) @(posedge clk_i);
      end
    end
  end

  // Main sequence
  initial begin
    dir_row_t             dir_tbl[14];
    logic     [15:0]      alphas[NumPhases];
    logic                 burst;
    imuctf_pkg::imu_out_t no_res;

    no_res = '0;
    dir_tbl = '{
      // after reset, level-less sample: all guard axes small
      '{'{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1,
        '{32'sd1, 32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, -32'sd1, -32'sd1}},
      '{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1,
        '{32'sd1, 32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}},
      '{'{1'b0, 16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'd10}, 1'b0, no_res},
      // full-scale rates over the longest dt drive integrals into saturation
      '{'{1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'hffff}, 1'b0, no_res},
      '{'{1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'hffff}, 1'b0, no_res},
      '{'{1'b0, 16'sh7fff, 16'sh8000, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'hffff}, 1'b0, no_res},
      // guard axes right at and just past the small threshold
      '{'{1'b0, 16'sd4, -16'sd4, 16'sd5, 16'sd16, -16'sd16, 16'sd0, 16'd100}, 1'b0, no_res},
      '{'{1'b1, -16'sd5, 16'sd5, -16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'd100}, 1'b0, no_res},
      // zero numerators, negative z
      '{'{1'b0, 16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'd1}, 1'b0, no_res},
      '{'{1'b1, 16'sd4096, -16'sd4096, -16'sd4096, 16'sd100, 16'sd200, 16'sd300, 16'd1000},
        1'b0, no_res},
      '{'{1'b1, 16'sd0, 16'sd4096, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff},
        1'b0, no_res},
      '{'{1'b0, -16'sd4096, 16'sd0, 16'sd4096, -16'sd50, 16'sd50, 16'sd7, 16'd20},
        1'b0, no_res},
      '{'{1'b1, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'h5555},
        1'b0, no_res},
      '{'{1'b0, 16'shaaaa, 16'shaaaa, 16'shaaaa, 16'shaaaa, 16'shaaaa, 16'shaaaa, 16'haaaa},
        1'b0, no_res}
    };
    // first phase keeps the reset value
    alphas = '{imuctf_pkg::AlphaReset, 16'd0, 16'hffff, 16'h8000, 16'($urandom), 16'd1};

    for (int i = 0; i < 6; i++) begin
      filt_st[i] = 0;
      integ_st[i] = 0;
    end
    alpha_cfg = imuctf_pkg::AlphaReset;
    err_cnt = 0;
    rx_cnt = 0;
    idle_cnt = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[r]) send_sample(dir_tbl[r].smp, dir_tbl[r].has_exp, dir_tbl[r].res, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain();
        write_alpha(alphas[p]);
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // some runs are offered back to back
        burst = ((n / 15) % 3) == 1;
        send_sample(rand_sample(), 1'b0, no_res, burst);
      end
    end
    drain();

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
